// ----- rtl/core/wahn_pkg.sv -----
// ----------------------------------------------------------------------------
// Wall avoid heading navigator package
// Payload types, register indexes and navigation constants.
// ----------------------------------------------------------------------------
package wahn_pkg;

    typedef struct packed {
        logic signed [15:0] gyro_rate_raw;
        logic [31:0]        now_ms;
        logic [9:0]         front_cm;
        logic [9:0]         side_a_cm;
        logic [9:0]         side_b_cm;
        logic [9:0]         side_c_cm;
    } wahn_in_t;

    typedef struct packed {
        logic [7:0]         thrust_duty;
        logic [7:0]         lift_duty;
        logic [12:0]        servo_compare;
        logic [2:0]         nav_mode;
        logic signed [31:0] heading;
    } wahn_out_t;

    localparam logic [2:0] CFG_GYRO_BIAS     = 3'd0;
    localparam logic [2:0] CFG_STEER_KP      = 3'd1;
    localparam logic [2:0] CFG_STEER_KI      = 3'd2;
    localparam logic [2:0] CFG_TURN_KP       = 3'd3;
    localparam logic [2:0] CFG_TURN_KD       = 3'd4;
    localparam logic [2:0] CFG_SLOW_DISTANCE = 3'd5;
    localparam logic [2:0] CFG_TURN_DISTANCE = 3'd6;
    localparam logic [2:0] CFG_STUCK_DISTANCE = 3'd7;

    localparam logic [2:0] M_CRUISE   = 3'd0;
    localparam logic [2:0] M_APPROACH = 3'd1;
    localparam logic [2:0] M_SCAN     = 3'd2;
    localparam logic [2:0] M_TURN     = 3'd3;
    localparam logic [2:0] M_STRAIGHT = 3'd4;

    localparam logic [12:0] CENTER_W  = 13'd3150;
    localparam logic [12:0] LEFT_W    = 13'd1750;
    localparam logic [12:0] RIGHT_W   = 13'd4500;
    localparam logic [12:0] MIRROR_W  = 13'd6300;
    localparam logic [9:0]  NO_ECHO_CM = 10'd999;
    localparam logic [31:0] QUARTER_TURN = 32'd9000;
    localparam logic [7:0]  THRUST_FULL = 8'd255;
    localparam logic [7:0]  THRUST_SLOW = 8'd110;
    localparam logic [7:0]  THRUST_STOP = 8'd0;
    localparam logic [7:0]  LIFT_NORMAL = 8'd230;
    localparam logic [7:0]  LIFT_LOW    = 8'd50;
    localparam logic [31:0] WALL_HOLD_MS  = 32'd900;
    localparam logic [31:0] SETTLE_MS     = 32'd200;
    localparam logic [31:0] SCAN_LIMIT_MS = 32'd1500;
    localparam logic [31:0] TURN_LIMIT_MS = 32'd3000;
    localparam logic [31:0] STRAIGHT_MAX_MS = 32'd500;

endpackage

// ----- rtl/core/wall_avoid_heading_navigator.sv -----
// ----------------------------------------------------------------------------
// Wall avoid heading navigator
// Per-tick yaw integration and five-mode wall avoidance steering.
// ----------------------------------------------------------------------------
// Each multiply-divide step runs load, a bit-serial multiply, a bit-serial divide
// and post; a tick runs two steps in scan, four in turn and five in the other modes,
// and the result is registered in the finish state.
// One tick at a time: in_stall holds off the next input transfer until the tick's
// result is registered and the block is idle; an output stall holds it off longer.
// Reset is asynchronous and active low and needs no clearing pass.
module wall_avoid_heading_navigator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wahn_pkg::wahn_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output wahn_pkg::wahn_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import wahn_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [2:0] OP_RATE    = 3'd0;
    localparam logic [2:0] OP_YAW     = 3'd1;
    localparam logic [2:0] OP_INTEG   = 3'd2;
    localparam logic [2:0] OP_STEER_P = 3'd3;
    localparam logic [2:0] OP_STEER_I = 3'd4;
    localparam logic [2:0] OP_TURN_P  = 3'd5;
    localparam logic [2:0] OP_TURN_D  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] op_reg;
    logic [4:0] cnt_reg;

    logic signed [15:0] bias_reg;
    logic [9:0] steer_kp_reg, steer_ki_reg, turn_kp_reg, turn_kd_reg;
    logic [9:0] slow_d_reg, turn_d_reg, stuck_d_reg;

    wahn_in_t item_reg;
    logic [31:0] dt_reg;

    logic signed [31:0] yaw_reg, tgt_reg, rate_reg, p_reg, i_reg;
    logic signed [13:0] integ_reg;
    logic [12:0] servo_reg;
    logic [31:0] prev_ms_reg, stuck_start_reg, phase_timer_reg, settle_start_reg;
    logic [2:0]  mode_reg;
    logic [9:0]  cruise_lg_reg, appr_lg_reg, stuck_ref_reg, left_open_reg;
    logic        stuck_armed_reg, scan_phase_reg, scan_armed_reg;

    logic [31:0] op_a_reg, op_b_reg, acc_reg, q_reg, res_reg;
    logic [9:0]  div_reg, rem_reg;
    logic        neg_reg;

    logic        out_valid_reg;
    wahn_out_t   out_data_reg;

    logic        in_go, out_free, fin_go;
    logic [31:0] acc_sum, acc_mag, q_shift, q_done;
    logic [10:0] rem_sh;
    logic        rem_ge;
    logic signed [31:0] err, integ_ext, integ_acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_go     = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_go    = (state_reg == S_FIN) && out_free;

    assign acc_sum   = acc_reg + (op_b_reg[0] ? op_a_reg : 32'd0);
    assign acc_mag   = acc_sum[31] ? (~acc_sum + 32'd1) : acc_sum;
    assign rem_sh    = {rem_reg, q_reg[31]};
    assign rem_ge    = rem_sh >= {1'b0, div_reg};
    assign q_shift   = {q_reg[30:0], rem_ge};
    assign q_done    = neg_reg ? (~q_shift + 32'd1) : q_shift;
    assign err       = tgt_reg - yaw_reg;
    assign integ_ext = {{18{integ_reg[13]}}, integ_reg};
    assign integ_acc = integ_ext + res_reg;

    // Mode logic evaluated once the arithmetic of the tick is complete.
    logic [7:0]  thrust, lift;
    logic [12:0] target, servo_next;
    logic [2:0]  mode_next;
    logic signed [31:0] tgt_next;
    logic signed [13:0] integ_next;
    logic [31:0] stuck_start_next, phase_timer_next, settle_start_next;
    logic [9:0]  cruise_lg_next, appr_lg_next, stuck_ref_next, left_open_next;
    logic        stuck_armed_next, scan_phase_next, scan_armed_next;
    logic signed [33:0] steer_sum, turn_sum;
    logic [12:0] steer_t, turn_t;
    logic [9:0]  cur, ma, mb, mc, mlo, mhi, open_cm, sdiff;
    logic        near_center, forced;
    logic signed [13:0] gdiff, sl_diff;
    logic [12:0] goal;
    logic [31:0] now;

    always_comb
    begin
        now = item_reg.now_ms;
        steer_sum = 34'sd3150 + {{2{p_reg[31]}}, p_reg} + {{2{i_reg[31]}}, i_reg};
        turn_sum  = 34'sd3150 + {{2{p_reg[31]}}, p_reg} - {{2{i_reg[31]}}, i_reg};
        if (steer_sum < 34'sd1750)
            steer_t = LEFT_W;
        else if (steer_sum > 34'sd4500)
            steer_t = RIGHT_W;
        else
            steer_t = steer_sum[12:0];
        if (turn_sum < 34'sd1750)
            turn_t = LEFT_W;
        else if (turn_sum > 34'sd4500)
            turn_t = RIGHT_W;
        else
            turn_t = turn_sum[12:0];
        near_center = (servo_reg > 13'd2950) && (servo_reg < 13'd3350);

        ma = (item_reg.side_a_cm == 10'd0) ? NO_ECHO_CM : item_reg.side_a_cm;
        mb = (item_reg.side_b_cm == 10'd0) ? NO_ECHO_CM : item_reg.side_b_cm;
        mc = (item_reg.side_c_cm == 10'd0) ? NO_ECHO_CM : item_reg.side_c_cm;
        mlo = (ma < mb) ? ma : mb;
        mhi = (ma < mb) ? mb : ma;
        mhi = (mhi < mc) ? mhi : mc;
        open_cm = (mlo > mhi) ? mlo : mhi;

        thrust = THRUST_FULL;
        lift = LIFT_NORMAL;
        target = CENTER_W;
        mode_next = mode_reg;
        tgt_next = tgt_reg;
        integ_next = integ_reg;
        stuck_start_next = stuck_start_reg;
        phase_timer_next = phase_timer_reg;
        settle_start_next = settle_start_reg;
        cruise_lg_next = cruise_lg_reg;
        appr_lg_next = appr_lg_reg;
        stuck_ref_next = stuck_ref_reg;
        left_open_next = left_open_reg;
        stuck_armed_next = stuck_armed_reg;
        scan_phase_next = scan_phase_reg;
        scan_armed_next = scan_armed_reg;
        forced = 1'b0;
        cur = 10'd0;
        sdiff = 10'd0;
        goal = LEFT_W;
        gdiff = 14'sd0;

        case (mode_reg)
            M_APPROACH:
            begin
                thrust = THRUST_SLOW;
                target = steer_t;
                if (item_reg.front_cm != 10'd0)
                    appr_lg_next = item_reg.front_cm;
                cur = (item_reg.front_cm != 10'd0) ? item_reg.front_cm : appr_lg_reg;
                if (cur < stuck_d_reg)
                begin
                    if (!stuck_armed_reg)
                    begin
                        stuck_armed_next = 1'b1;
                        stuck_start_next = now;
                        stuck_ref_next = cur;
                    end
                    else
                    begin
                        sdiff = (cur > stuck_ref_reg) ? cur - stuck_ref_reg
                                                      : stuck_ref_reg - cur;
                        if (sdiff > 10'd3)
                        begin
                            stuck_start_next = now;
                            stuck_ref_next = cur;
                        end
                        else if (now - stuck_start_reg >= WALL_HOLD_MS)
                            forced = 1'b1;
                    end
                end
                else
                    stuck_armed_next = 1'b0;
                if ((cur < turn_d_reg) || forced)
                begin
                    appr_lg_next = NO_ECHO_CM;
                    stuck_armed_next = 1'b0;
                    scan_phase_next = 1'b0;
                    scan_armed_next = 1'b0;
                    phase_timer_next = now;
                    mode_next = M_SCAN;
                end
            end
            M_SCAN:
            begin
                goal = scan_phase_reg ? RIGHT_W : LEFT_W;
                gdiff = $signed({1'b0, servo_reg}) - $signed({1'b0, goal});
                thrust = THRUST_STOP;
                lift = LIFT_LOW;
                target = goal;
                if ((gdiff >= -14'sd150 && gdiff <= 14'sd150)
                    || (now - phase_timer_reg >= SCAN_LIMIT_MS))
                begin
                    if (!scan_armed_reg)
                    begin
                        settle_start_next = now;
                        scan_armed_next = 1'b1;
                    end
                    else if (now - settle_start_reg >= SETTLE_MS)
                    begin
                        scan_armed_next = 1'b0;
                        phase_timer_next = now;
                        if (!scan_phase_reg)
                        begin
                            left_open_next = open_cm;
                            scan_phase_next = 1'b1;
                        end
                        else
                        begin
                            tgt_next = (left_open_reg > open_cm) ? tgt_reg - QUARTER_TURN
                                                                 : tgt_reg + QUARTER_TURN;
                            target = CENTER_W;
                            mode_next = M_TURN;
                        end
                    end
                end
            end
            M_TURN:
            begin
                lift = LIFT_LOW;
                target = turn_t;
                if ((err >= -32'sd300 && err <= 32'sd300)
                    || (now - phase_timer_reg >= TURN_LIMIT_MS))
                begin
                    lift = LIFT_NORMAL;
                    integ_next = 14'sd0;
                    phase_timer_next = now;
                    mode_next = M_STRAIGHT;
                end
            end
            M_STRAIGHT:
            begin
                thrust = THRUST_SLOW;
                target = steer_t;
                if (near_center || (now - phase_timer_reg >= STRAIGHT_MAX_MS))
                    mode_next = M_CRUISE;
            end
            default:
            begin
                target = steer_t;
                mode_next = M_CRUISE;
                if (item_reg.front_cm != 10'd0)
                    cruise_lg_next = item_reg.front_cm;
                cur = (item_reg.front_cm != 10'd0) ? item_reg.front_cm : cruise_lg_reg;
                if (near_center && (cur < slow_d_reg))
                begin
                    cruise_lg_next = NO_ECHO_CM;
                    stuck_armed_next = 1'b0;
                    mode_next = M_APPROACH;
                end
            end
        endcase

        sl_diff = $signed({1'b0, target}) - $signed({1'b0, servo_reg});
        if (sl_diff > 14'sd150)
            servo_next = servo_reg + 13'd150;
        else if (sl_diff < -14'sd150)
            servo_next = servo_reg - 13'd150;
        else
            servo_next = target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_RATE;
            cnt_reg <= 5'd0;
            bias_reg <= 16'sd0;
            steer_kp_reg <= 10'd30;
            steer_ki_reg <= 10'd2;
            turn_kp_reg <= 10'd18;
            turn_kd_reg <= 10'd90;
            slow_d_reg <= 10'd45;
            turn_d_reg <= 10'd28;
            stuck_d_reg <= 10'd32;
            yaw_reg <= 32'sd0;
            tgt_reg <= 32'sd0;
            integ_reg <= 14'sd0;
            servo_reg <= CENTER_W;
            prev_ms_reg <= 32'd0;
            mode_reg <= M_CRUISE;
            cruise_lg_reg <= NO_ECHO_CM;
            appr_lg_reg <= NO_ECHO_CM;
            stuck_armed_reg <= 1'b0;
            stuck_ref_reg <= 10'd0;
            stuck_start_reg <= 32'd0;
            scan_phase_reg <= 1'b0;
            scan_armed_reg <= 1'b0;
            phase_timer_reg <= 32'd0;
            settle_start_reg <= 32'd0;
            left_open_reg <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GYRO_BIAS:      bias_reg <= cfg_data;
                    CFG_STEER_KP:       steer_kp_reg <= cfg_data[9:0];
                    CFG_STEER_KI:       steer_ki_reg <= cfg_data[9:0];
                    CFG_TURN_KP:        turn_kp_reg <= cfg_data[9:0];
                    CFG_TURN_KD:        turn_kd_reg <= cfg_data[9:0];
                    CFG_SLOW_DISTANCE:  slow_d_reg <= cfg_data[9:0];
                    CFG_TURN_DISTANCE:  turn_d_reg <= cfg_data[9:0];
                    CFG_STUCK_DISTANCE: stuck_d_reg <= cfg_data[9:0];
                    default:            bias_reg <= bias_reg;
                endcase
            end

            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_go)
                    begin
                        item_reg <= in_data;
                        dt_reg <= (in_data.now_ms >= prev_ms_reg)
                                  ? in_data.now_ms - prev_ms_reg : 32'd0;
                        prev_ms_reg <= in_data.now_ms;
                        op_reg <= OP_RATE;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    acc_reg <= 32'd0;
                    cnt_reg <= 5'd0;
                    case (op_reg)
                        OP_RATE:
                        begin
                            op_a_reg <= {{16{item_reg.gyro_rate_raw[15]}},
                                         item_reg.gyro_rate_raw};
                            op_b_reg <= 32'd100;
                            div_reg <= 10'd131;
                        end
                        OP_YAW:
                        begin
                            op_a_reg <= rate_reg - {{16{bias_reg[15]}}, bias_reg};
                            op_b_reg <= dt_reg;
                            div_reg <= 10'd1000;
                        end
                        OP_INTEG:
                        begin
                            op_a_reg <= err;
                            op_b_reg <= dt_reg;
                            div_reg <= 10'd1000;
                        end
                        OP_STEER_P:
                        begin
                            op_a_reg <= err;
                            op_b_reg <= {22'd0, steer_kp_reg};
                            div_reg <= 10'd100;
                        end
                        OP_STEER_I:
                        begin
                            op_a_reg <= integ_ext;
                            op_b_reg <= {22'd0, steer_ki_reg};
                            div_reg <= 10'd100;
                        end
                        OP_TURN_P:
                        begin
                            op_a_reg <= err;
                            op_b_reg <= {22'd0, turn_kp_reg};
                            div_reg <= 10'd100;
                        end
                        default:
                        begin
                            op_a_reg <= rate_reg;
                            op_b_reg <= {22'd0, turn_kd_reg};
                            div_reg <= 10'd100;
                        end
                    endcase
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    op_a_reg <= {op_a_reg[30:0], 1'b0};
                    op_b_reg <= {1'b0, op_b_reg[31:1]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        neg_reg <= acc_sum[31];
                        q_reg <= acc_mag;
                        rem_reg <= 10'd0;
                        state_reg <= S_DIV;
                    end
                    else
                        acc_reg <= acc_sum;
                end
                S_DIV:
                begin
                    rem_reg <= rem_ge ? 10'(rem_sh - {1'b0, div_reg}) : rem_sh[9:0];
                    q_reg <= q_shift;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        res_reg <= q_done;
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    case (op_reg)
                        OP_RATE:
                        begin
                            rate_reg <= res_reg;
                            op_reg <= OP_YAW;
                            state_reg <= S_LOAD;
                        end
                        OP_YAW:
                        begin
                            yaw_reg <= yaw_reg + res_reg;
                            if (mode_reg == M_TURN)
                            begin
                                op_reg <= OP_TURN_P;
                                state_reg <= S_LOAD;
                            end
                            else if (mode_reg == M_SCAN)
                                state_reg <= S_FIN;
                            else
                            begin
                                op_reg <= OP_INTEG;
                                state_reg <= S_LOAD;
                            end
                        end
                        OP_INTEG:
                        begin
                            if (integ_acc < -32'sd8000)
                                integ_reg <= -14'sd8000;
                            else if (integ_acc > 32'sd8000)
                                integ_reg <= 14'sd8000;
                            else
                                integ_reg <= integ_acc[13:0];
                            op_reg <= OP_STEER_P;
                            state_reg <= S_LOAD;
                        end
                        OP_STEER_P, OP_TURN_P:
                        begin
                            p_reg <= res_reg;
                            op_reg <= (op_reg == OP_STEER_P) ? OP_STEER_I : OP_TURN_D;
                            state_reg <= S_LOAD;
                        end
                        OP_STEER_I:
                        begin
                            if ($signed(res_reg) < -32'sd600)
                                i_reg <= -32'sd600;
                            else if ($signed(res_reg) > 32'sd600)
                                i_reg <= 32'sd600;
                            else
                                i_reg <= res_reg;
                            state_reg <= S_FIN;
                        end
                        default:
                        begin
                            i_reg <= res_reg;
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        mode_reg <= mode_next;
                        tgt_reg <= tgt_next;
                        integ_reg <= integ_next;
                        servo_reg <= servo_next;
                        stuck_start_reg <= stuck_start_next;
                        phase_timer_reg <= phase_timer_next;
                        settle_start_reg <= settle_start_next;
                        cruise_lg_reg <= cruise_lg_next;
                        appr_lg_reg <= appr_lg_next;
                        stuck_ref_reg <= stuck_ref_next;
                        left_open_reg <= left_open_next;
                        stuck_armed_reg <= stuck_armed_next;
                        scan_phase_reg <= scan_phase_next;
                        scan_armed_reg <= scan_armed_next;
                        out_data_reg.thrust_duty <= thrust;
                        out_data_reg.lift_duty <= lift;
                        out_data_reg.servo_compare <= MIRROR_W - servo_next;
                        out_data_reg.nav_mode <= mode_next;
                        out_data_reg.heading <= yaw_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= M_STRAIGHT)
        else $error("navigation mode left its legal range");

    a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
        servo_reg >= LEFT_W && servo_reg <= RIGHT_W)
        else $error("servo width outside rudder limits");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg >= -14'sd8000 && integ_reg <= 14'sd8000)
        else $error("steering integral outside its clamp");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_LOAD && op_reg == OP_RATE)
        else $error("accepted transfer did not start the rate step");
`endif

endmodule
